@@ sv/countdown_timer_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Countdown timer controller: assertion macros
// Concurrent assertion wrappers shared by the RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_CONTROLLER_MACROS_SVH
`define COUNTDOWN_TIMER_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at every edge outside reset.
`define CTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define CTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ sv/ctc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and codes of the countdown timer controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctc_pkg;

  localparam int TIME_WIDTH_DEF  = 16;
  localparam int TOTAL_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int PHASE_W  = 4;
  localparam int STEP_W   = 12;
  localparam int STATUS_W = 2;
  localparam int STATE_W  = 3;
  localparam int SHOWN_W  = 32;
  localparam int MSG_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Register reset values
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(60);
  localparam logic [PHASE_W-1:0] BEEP_RST  = PHASE_W'(5);
  localparam logic [PHASE_W-1:0] COUNT_RST = PHASE_W'(10);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SECONDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_PHASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_PHASE  = 2'd2;

  // Event codes
  localparam logic [MODE_W-1:0] EV_INC   = 3'd0;
  localparam logic [MODE_W-1:0] EV_DEC   = 3'd1;
  localparam logic [MODE_W-1:0] EV_TICK  = 3'd2;
  localparam logic [MODE_W-1:0] EV_START = 3'd3;
  localparam logic [MODE_W-1:0] EV_ABORT = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] RS_IGNORED = 2'd0;
  localparam logic [STATUS_W-1:0] RS_HANDLED = 2'd1;
  localparam logic [STATUS_W-1:0] RS_TRANS   = 2'd2;

  // Message codes
  localparam logic [MSG_W-1:0] MSG_NONE       = 2'd0;
  localparam logic [MSG_W-1:0] MSG_SET_TIME   = 2'd1;
  localparam logic [MSG_W-1:0] MSG_PAUSED     = 2'd2;
  localparam logic [MSG_W-1:0] MSG_PRODUCTIVE = 2'd3;

  // State code of idle, as seen on the result channel
  localparam logic [STATE_W-1:0] STATE_IDLE_CODE = 3'd0;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PHASE_W-1:0] sub_second;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [STATE_W-1:0]  new_state;
    logic                clear_display;
    logic                show_time;
    logic [SHOWN_W-1:0]  shown_time;
    logic [MSG_W-1:0]    message;
    logic                beep;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_seconds;
    logic [PHASE_W-1:0] beep_phase;
    logic [PHASE_W-1:0] count_phase;
  } cfg_regs_t;

endpackage

@@ sv/ctc_cfg.sv @@
// ----------------------------------------------------------------------------
// ctc_cfg
// Configuration register file: step size and the two tick phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_cfg import ctc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;

  // Always take writes; landing them only while the datapath is quiet is the user's duty, unchecked here.
  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.step_seconds <= STEP_RST;
      regs_r.beep_phase   <= BEEP_RST;
      regs_r.count_phase  <= COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_SECONDS: regs_r.step_seconds <= cfg_wdata[STEP_W-1:0];
        REG_BEEP_PHASE:   regs_r.beep_phase   <= cfg_wdata[PHASE_W-1:0];
        REG_COUNT_PHASE:  regs_r.count_phase  <= cfg_wdata[PHASE_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule

@@ sv/ctc_in_stage.sv @@
// ----------------------------------------------------------------------------
// ctc_in_stage
// Input register: holds one event until the state machine takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_in_stage import ctc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     item_vld,
  output in_item_t item,
  input  logic     item_take
);

  logic     vld_r;
  in_item_t item_r;

  // Stall only while a held event cannot move on this cycle.
  assign in_stall = vld_r && !item_take;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

@@ sv/ctc_fsm.sv @@
// ----------------------------------------------------------------------------
// ctc_fsm
// Timer state machine with time counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "countdown_timer_controller_macros.svh"

module ctc_fsm import ctc_pkg::*; #(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      item_vld,
  input  in_item_t  item,
  output logic      item_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int SUM_W  = ((TIME_WIDTH > STEP_W) ? TIME_WIDTH : STEP_W) + 1;
  localparam int ACC_W  = ((TOTAL_WIDTH > TIME_WIDTH) ? TOTAL_WIDTH : TIME_WIDTH) + 1;
  localparam int DISP_W = (TOTAL_WIDTH > SHOWN_W) ? TOTAL_WIDTH : (SHOWN_W + 1);

  typedef enum logic [STATE_W-1:0] {
    S_IDLE  = 3'd0,
    S_SET   = 3'd1,
    S_PAUSE = 3'd2,
    S_COUNT = 3'd3,
    S_STATS = 3'd4
  } state_t;

  state_t                 state_r, state_nxt, dst;
  logic [TIME_WIDTH-1:0]  set_time_r, set_time_nxt;
  logic [TIME_WIDTH-1:0]  elapsed_r, elapsed_nxt;
  logic [TOTAL_WIDTH-1:0] total_r, total_nxt;
  logic                   out_vld_r;
  out_item_t              out_r, res;

  logic [SUM_W-1:0]       dec_diff;
  logic                   can_dec;
  logic [TIME_WIDTH-1:0]  step_up_val, step_down_val, elapsed_inc;
  logic                   is_beep_tick, is_count_tick;

  function automatic logic [TIME_WIDTH-1:0] time_add(logic [TIME_WIDTH-1:0] a,
                                                     logic [STEP_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if ((s >> TIME_WIDTH) != '0) time_add = '1;
    else                         time_add = s[TIME_WIDTH-1:0];
  endfunction

  function automatic logic [TOTAL_WIDTH-1:0] total_add(logic [TOTAL_WIDTH-1:0] a,
                                                       logic [TIME_WIDTH-1:0] b);
    logic [ACC_W-1:0] s;
    s = ACC_W'(a) + ACC_W'(b);
    if ((s >> TOTAL_WIDTH) != '0) total_add = '1;
    else                          total_add = s[TOTAL_WIDTH-1:0];
  endfunction

  function automatic logic [SHOWN_W-1:0] clamp_total(logic [TOTAL_WIDTH-1:0] v);
    logic [DISP_W-1:0] x;
    x = DISP_W'(v);
    if ((x >> SHOWN_W) != '0) clamp_total = '1;
    else                      clamp_total = x[SHOWN_W-1:0];
  endfunction

  assign item_take     = item_vld && (!out_vld_r || !out_stall);
  assign out_valid     = out_vld_r;
  assign out_data      = out_r;

  assign step_up_val   = time_add(set_time_r, cfg.step_seconds);
  assign dec_diff      = SUM_W'(set_time_r) - SUM_W'(cfg.step_seconds);
  assign can_dec       = SUM_W'(set_time_r) >= SUM_W'(cfg.step_seconds);
  assign step_down_val = dec_diff[TIME_WIDTH-1:0];
  assign elapsed_inc   = (elapsed_r == '1) ? elapsed_r : elapsed_r + TIME_WIDTH'(1);
  assign is_beep_tick  = (item.mode == EV_TICK) && (item.sub_second == cfg.beep_phase);
  assign is_count_tick = (item.mode == EV_TICK) && (item.sub_second == cfg.count_phase);

  always_comb begin
    set_time_nxt = set_time_r;
    elapsed_nxt  = elapsed_r;
    total_nxt    = total_r;
    dst          = state_r;
    res          = '0;
    res.status   = RS_IGNORED;

    // event action in the source state
    case (state_r)
      S_IDLE: begin
        if (item.mode == EV_INC) begin
          set_time_nxt = step_up_val;
          dst          = S_SET;
          res.status   = RS_TRANS;
        end else if (item.mode == EV_START) begin
          dst        = S_STATS;
          res.status = RS_TRANS;
        end else if (is_beep_tick) begin
          res.beep   = 1'b1;
          res.status = RS_HANDLED;
        end
      end
      S_SET: begin
        if (item.mode == EV_INC) begin
          set_time_nxt   = step_up_val;
          res.show_time  = 1'b1;
          res.shown_time = SHOWN_W'(step_up_val);
          res.status     = RS_HANDLED;
        end else if (item.mode == EV_DEC) begin
          if (can_dec) begin
            set_time_nxt   = step_down_val;
            res.show_time  = 1'b1;
            res.shown_time = SHOWN_W'(step_down_val);
            res.status     = RS_HANDLED;
          end
        end else if (item.mode == EV_ABORT) begin
          dst        = S_IDLE;
          res.status = RS_TRANS;
        end else if (item.mode == EV_START && can_dec) begin
          dst        = S_COUNT;
          res.status = RS_TRANS;
        end
      end
      S_PAUSE: begin
        if (item.mode == EV_INC) begin
          set_time_nxt = step_up_val;
          dst          = S_SET;
          res.status   = RS_TRANS;
        end else if (item.mode == EV_DEC) begin
          if (can_dec) begin
            set_time_nxt = step_down_val;
            dst          = S_SET;
            res.status   = RS_TRANS;
          end
        end else if (item.mode == EV_ABORT) begin
          dst        = S_IDLE;
          res.status = RS_TRANS;
        end else if (item.mode == EV_START) begin
          dst        = S_COUNT;
          res.status = RS_TRANS;
        end
      end
      S_COUNT: begin
        if (item.mode == EV_START) begin
          dst        = S_PAUSE;
          res.status = RS_TRANS;
        end else if (item.mode == EV_ABORT) begin
          dst        = S_IDLE;
          res.status = RS_TRANS;
        end else if (is_count_tick) begin
          if (set_time_r != '0) begin
            set_time_nxt = set_time_r - TIME_WIDTH'(1);
            elapsed_nxt  = elapsed_inc;
          end
          res.show_time  = 1'b1;
          res.shown_time = SHOWN_W'(set_time_nxt);
          if (set_time_nxt == '0) begin
            dst        = S_IDLE;
            res.status = RS_TRANS;
          end else begin
            res.status = RS_HANDLED;
          end
        end
      end
      S_STATS: begin
        if (is_count_tick) begin
          dst        = S_IDLE;
          res.status = RS_TRANS;
        end
      end
      default: begin
        // unreachable state: ignore the event
      end
    endcase

    if (res.status == RS_TRANS) begin
      // exit action of the source state
      if (state_r == S_COUNT) begin
        total_nxt   = total_add(total_r, elapsed_nxt);
        elapsed_nxt = '0;
      end else begin
        res.clear_display = 1'b1;
      end
      // entry action of the target state
      case (dst)
        S_IDLE: begin
          set_time_nxt   = '0;
          elapsed_nxt    = '0;
          res.message    = MSG_SET_TIME;
          res.show_time  = 1'b1;
          res.shown_time = '0;
        end
        S_SET: begin
          res.show_time  = 1'b1;
          res.shown_time = SHOWN_W'(set_time_nxt);
        end
        S_PAUSE: begin
          res.message = MSG_PAUSED;
        end
        S_STATS: begin
          res.show_time  = 1'b1;
          res.shown_time = clamp_total(total_nxt);
          res.message    = MSG_PRODUCTIVE;
        end
        default: begin
          // countdown has no entry action
        end
      endcase
    end

    state_nxt     = dst;
    res.new_state = dst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      set_time_r <= '0;
      elapsed_r  <= '0;
      total_r    <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (item_take) begin
        state_r    <= state_nxt;
        set_time_r <= set_time_nxt;
        elapsed_r  <= elapsed_nxt;
        total_r    <= total_nxt;
        out_r      <= res;
      end
      out_vld_r <= item_take || (out_vld_r && out_stall);
    end
  end

  `CTC_ASSERT(a_ignored_is_quiet, clk, rst_n,
    (out_vld_r && out_r.status == RS_IGNORED) |->
      (!out_r.show_time && !out_r.clear_display && !out_r.beep &&
       out_r.message == MSG_NONE),
    "ignored event produced actions")
  `CTC_ASSERT(a_state_matches_result, clk, rst_n,
    out_vld_r |-> (out_r.new_state == state_r),
    "held result disagrees with current state")
  `CTC_ASSERT(a_idle_clears_times, clk, rst_n,
    (out_vld_r && out_r.status == RS_TRANS && out_r.new_state == STATE_IDLE_CODE) |->
      (set_time_r == '0 && elapsed_r == '0),
    "entry to idle left a time value")
  `CTC_ASSERT(a_hidden_time_zero, clk, rst_n,
    (out_vld_r && !out_r.show_time) |-> (out_r.shown_time == '0),
    "hidden time field not zero")
  `CTC_ASSERT(a_stall_holds_state, clk, rst_n,
    (out_vld_r && out_stall) |=> $stable(state_r),
    "state moved while the result was stalled")

endmodule

@@ sv/countdown_timer_controller.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_controller
// Five-state countdown timer (idle, set, pause, countdown, stats) driven by
// button and tick events, one result per event.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one event per transaction (mode, sub_second), valid/stall.
//   out_* : one result per event (status, new_state, display and beep
//           requests), valid/stall, in event order.
//   cfg_* : register writes (step_seconds, beep_phase, count_phase), taken
//           whenever cfg_valid is high; write only while no event is in
//           flight.
// Timing: an event is registered in the input register at acceptance; once
// the output register has room, its result is loaded there and out_valid
// rises. One event per cycle is sustained while out_stall is low, with the
// state update lying between the input and output registers.
// Reset (rst_n low, synchronous): state idle, all times and the productive
// total cleared, registers back to 60 / 5 / 10, both channels empty.
// Stall: while out_stall holds the result, the next event is still taken
// into the input register; further events stall until the result drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module countdown_timer_controller import ctc_pkg::*; #(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // event channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t regs;
  logic      item_vld;
  logic      item_take;
  in_item_t  item;

  // Hold the live register values for the state machine.
  ctc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // Capture each event; advance it when the result register has room.
  ctc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  // Run the event, update the timer state and register the result.
  ctc_fsm #(
    .TIME_WIDTH  (TIME_WIDTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (regs),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ dv/ctc_result_checker.sv @@
// ----------------------------------------------------------------------------
// ctc_result_checker
// Watches the event, result and register channels of the countdown timer
// controller, predicts each result from its own copy of the timer state and
// compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_result_checker import ctc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int TW   = TIME_WIDTH_DEF;
  localparam int TOTW = TOTAL_WIDTH_DEF;

  typedef enum logic [STATE_W-1:0] {
    T_IDLE  = 3'd0,
    T_SET   = 3'd1,
    T_PAUSE = 3'd2,
    T_COUNT = 3'd3,
    T_STATS = 3'd4
  } timer_state_e;

  cfg_regs_t       regs;
  timer_state_e    cur_state;
  logic [TW-1:0]   set_time;
  logic [TW-1:0]   elapsed;
  logic [TOTW-1:0] total;
  out_item_t       expected_q[$];
  int              err_cnt = 0;

  function automatic logic [TW-1:0] sat_add_time(input logic [TW-1:0] a,
                                                 input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? '1 : s[TW-1:0];
  endfunction

  // Apply one event to the timer copy and return the result it gives.
  function automatic out_item_t next_timer_result(input in_item_t ev);
    out_item_t           r;
    timer_state_e        src;
    timer_state_e        dst;
    logic [STATUS_W-1:0] st;
    logic [TW-1:0]       step;
    logic [TOTW:0]       sum;
    r    = '0;
    src  = cur_state;
    dst  = src;
    st   = RS_IGNORED;
    step = TW'(regs.step_seconds);
    case (src)
      T_IDLE: begin
        if (ev.mode == EV_INC) begin
          set_time = sat_add_time(set_time, step);
          dst = T_SET;
          st  = RS_TRANS;
        end else if (ev.mode == EV_START) begin
          dst = T_STATS;
          st  = RS_TRANS;
        end else if (ev.mode == EV_TICK && ev.sub_second == regs.beep_phase) begin
          r.beep = 1'b1;
          st     = RS_HANDLED;
        end
      end
      T_SET: begin
        if (ev.mode == EV_INC) begin
          set_time     = sat_add_time(set_time, step);
          r.show_time  = 1'b1;
          r.shown_time = SHOWN_W'(set_time);
          st           = RS_HANDLED;
        end else if (ev.mode == EV_DEC) begin
          if (set_time >= step) begin
            set_time     = set_time - step;
            r.show_time  = 1'b1;
            r.shown_time = SHOWN_W'(set_time);
            st           = RS_HANDLED;
          end
        end else if (ev.mode == EV_ABORT) begin
          dst = T_IDLE;
          st  = RS_TRANS;
        end else if (ev.mode == EV_START && set_time >= step) begin
          dst = T_COUNT;
          st  = RS_TRANS;
        end
      end
      T_PAUSE: begin
        if (ev.mode == EV_INC) begin
          set_time = sat_add_time(set_time, step);
          dst = T_SET;
          st  = RS_TRANS;
        end else if (ev.mode == EV_DEC) begin
          if (set_time >= step) begin
            set_time = set_time - step;
            dst = T_SET;
            st  = RS_TRANS;
          end
        end else if (ev.mode == EV_ABORT) begin
          dst = T_IDLE;
          st  = RS_TRANS;
        end else if (ev.mode == EV_START) begin
          dst = T_COUNT;
          st  = RS_TRANS;
        end
      end
      T_COUNT: begin
        if (ev.mode == EV_START) begin
          dst = T_PAUSE;
          st  = RS_TRANS;
        end else if (ev.mode == EV_ABORT) begin
          dst = T_IDLE;
          st  = RS_TRANS;
        end else if (ev.mode == EV_TICK && ev.sub_second == regs.count_phase) begin
          if (set_time != '0) begin
            set_time = set_time - 1'b1;
            elapsed  = sat_add_time(elapsed, TW'(1));
          end
          r.show_time  = 1'b1;
          r.shown_time = SHOWN_W'(set_time);
          if (set_time == '0) begin
            dst = T_IDLE;
            st  = RS_TRANS;
          end else begin
            st = RS_HANDLED;
          end
        end
      end
      T_STATS: begin
        if (ev.mode == EV_TICK && ev.sub_second == regs.count_phase) begin
          dst = T_IDLE;
          st  = RS_TRANS;
        end
      end
      default: ;
    endcase

    if (st == RS_TRANS) begin
      // exit action of the source state
      if (src == T_COUNT) begin
        sum     = {1'b0, total} + (TOTW + 1)'(elapsed);
        total   = sum[TOTW] ? '1 : sum[TOTW-1:0];
        elapsed = '0;
      end else begin
        r.clear_display = 1'b1;
      end
      // entry action of the target state
      case (dst)
        T_IDLE: begin
          set_time     = '0;
          elapsed      = '0;
          r.message    = MSG_SET_TIME;
          r.show_time  = 1'b1;
          r.shown_time = '0;
        end
        T_SET: begin
          r.show_time  = 1'b1;
          r.shown_time = SHOWN_W'(set_time);
        end
        T_PAUSE: r.message = MSG_PAUSED;
        T_STATS: begin
          r.show_time  = 1'b1;
          r.shown_time = SHOWN_W'(total);
          r.message    = MSG_PRODUCTIVE;
        end
        default: ;
      endcase
    end

    cur_state   = dst;
    r.status    = st;
    r.new_state = dst;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t exp_r;
    logic [6:0] diff;
    if (!rst_n) begin
      regs.step_seconds = STEP_RST;
      regs.beep_phase   = BEEP_RST;
      regs.count_phase  = COUNT_RST;
      cur_state         = T_IDLE;
      set_time          = '0;
      elapsed           = '0;
      total             = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_SECONDS: regs.step_seconds = cfg_wdata[STEP_W-1:0];
          REG_BEEP_PHASE:   regs.beep_phase   = cfg_wdata[PHASE_W-1:0];
          REG_COUNT_PHASE:  regs.count_phase  = cfg_wdata[PHASE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(next_timer_result(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] unexpected result transaction: %p", $realtime, out_data);
        end else begin
          exp_r = expected_q.pop_front();
          diff = {out_data.status        !== exp_r.status,
                  out_data.new_state     !== exp_r.new_state,
                  out_data.clear_display !== exp_r.clear_display,
                  out_data.show_time     !== exp_r.show_time,
                  out_data.shown_time    !== exp_r.shown_time,
                  out_data.message       !== exp_r.message,
                  out_data.beep          !== exp_r.beep};
          if (diff != '0) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] result mismatch (fields %b)\n  expected %p\n  actual   %p",
                       $realtime, diff, exp_r, out_data);
          end
        end
      end
    end
    // publish after the edge so readers at this edge see a stable value
    mismatches  <= err_cnt;
    outstanding <= expected_q.size();
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the countdown timer controller: a directed walk
// through every state and corner case, then random phases under a range of
// register settings, with random idling on both channels and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ctc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction on any channel
  localparam int HOLD_CYCLES = 200;   // long result hold-off
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 55;
  localparam int MAX_WAIT    = 13;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_UNUSED_HI = 3'd7;
  localparam logic [STEP_W-1:0]    STEP_MAX       = '1;
  localparam logic [PHASE_W-1:0]   PHASE_MAX      = '1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;

  // Knobs shared between the stimulus and the result sink
  bit src_burst  = 1'b0;   // sender offers back to back
  bit sink_burst = 1'b0;   // receiver never stalls
  bit hold_req   = 1'b0;   // receiver holds off once for a long stretch

  // Tick phases as last programmed, so ticks can hit them often
  logic [PHASE_W-1:0] cur_beep  = BEEP_RST;
  logic [PHASE_W-1:0] cur_count = COUNT_RST;

  countdown_timer_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ctc_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: end the run when no channel moves a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result sink: draw a stall length per result, take the long hold-off when
  // asked, then accept exactly one result transaction.
  initial begin : result_sink
    int wait_cycles;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        wait_cycles = HOLD_CYCLES;
        hold_req    = 1'b0;
      end else if (sink_burst) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, MAX_WAIT);
      end
      // raise stall only when a wait is drawn, so it never toggles in one step
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic in_item_t make_ev(input logic [MODE_W-1:0] mode,
                                       input logic [PHASE_W-1:0] sub);
    in_item_t ev;
    ev.mode       = mode;
    ev.sub_second = sub;
    return ev;
  endfunction

  // Weighted event mix: ticks mostly land on the count phase so countdowns
  // run to zero; a few unused modes act as noise.
  function automatic in_item_t random_event();
    in_item_t ev;
    int       pick;
    int       phase_pick;
    pick          = $urandom_range(0, 99);
    phase_pick    = $urandom_range(0, 9);
    ev.sub_second = PHASE_W'($urandom_range(0, 15));
    if (pick < 20) begin
      ev.mode = EV_INC;
    end else if (pick < 30) begin
      ev.mode = EV_DEC;
    end else if (pick < 75) begin
      ev.mode = EV_TICK;
      if (phase_pick < 7)
        ev.sub_second = cur_count;
      else if (phase_pick == 7)
        ev.sub_second = cur_beep;
    end else if (pick < 88) begin
      ev.mode = EV_START;
    end else if (pick < 95) begin
      ev.mode = EV_ABORT;
    end else begin
      ev.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    end
    return ev;
  endfunction

  // Offer one event after a random gap, or none when src_burst is set; hold it until the block takes it.
  task automatic send_event(input in_item_t ev);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Leave cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program all registers; phase writes carry junk in the upper bits,
  // which the block must drop.
  task automatic program_timer(input logic [STEP_W-1:0] step,
                               input logic [PHASE_W-1:0] beep,
                               input logic [PHASE_W-1:0] count,
                               input bit poke_unused);
    logic [CFG_DATA_W-PHASE_W-1:0] junk;
    junk = (CFG_DATA_W - PHASE_W)'($urandom);
    write_reg(REG_STEP_SECONDS, step);
    write_reg(REG_BEEP_PHASE, {junk, beep});
    junk = (CFG_DATA_W - PHASE_W)'($urandom);
    write_reg(REG_COUNT_PHASE, {junk, count});
    if (poke_unused)
      write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    cur_beep  = beep;
    cur_count = count;
  endtask

  initial begin : stimulus
    logic [STEP_W-1:0]  step;
    logic [PHASE_W-1:0] beep;
    logic [PHASE_W-1:0] count;
    int                 inc_run;

    // Hold reset low, then release it once.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk at reset register values: step 60, beep 5, count 10.
    send_event(make_ev(EV_TICK, BEEP_RST));        // beep tick in idle
    send_event(make_ev(EV_TICK, BEEP_RST - 1'b1)); // other idle tick, ignored
    send_event(make_ev(MODE_UNUSED_LO, '0));       // unused modes
    send_event(make_ev(MODE_UNUSED_HI, PHASE_MAX));
    send_event(make_ev(EV_DEC, '0));               // not listed in idle
    send_event(make_ev(EV_ABORT, '0));
    send_event(make_ev(EV_START, '0));             // idle -> stats
    send_event(make_ev(EV_INC, '0));               // ignored in stats
    send_event(make_ev(EV_TICK, COUNT_RST));       // stats -> idle
    send_event(make_ev(EV_INC, '0));               // idle -> set, real transition
    send_event(make_ev(EV_INC, '0));
    send_event(make_ev(EV_DEC, '0));
    send_event(make_ev(EV_DEC, '0));               // down to zero
    send_event(make_ev(EV_DEC, '0));               // below one step, ignored
    send_event(make_ev(EV_START, '0));             // start refused at zero
    send_event(make_ev(EV_INC, '0));
    send_event(make_ev(EV_START, '0));             // set -> countdown
    send_event(make_ev(EV_TICK, COUNT_RST));       // count one second
    send_event(make_ev(EV_TICK, COUNT_RST - 1'b1));// off-phase tick, ignored
    send_event(make_ev(EV_START, '0));             // countdown -> pause
    send_event(make_ev(EV_DEC, '0));               // pause decrement below step
    send_event(make_ev(EV_START, '0));             // pause -> countdown
    send_event(make_ev(EV_ABORT, '0));             // leave countdown, add to total
    send_event(make_ev(EV_START, '0));             // stats shows the total
    send_event(make_ev(EV_TICK, COUNT_RST));
    wait_drained();

    // Zero step: start from set with zero time, then count at zero.
    program_timer('0, PHASE_MAX, '0, 1'b1);
    send_event(make_ev(EV_INC, '0));
    send_event(make_ev(EV_START, '0));
    send_event(make_ev(EV_TICK, '0));
    wait_drained();

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 5)
        0: step = STEP_W'($urandom_range(1, 6));
        1: step = '0;
        2: step = STEP_MAX;
        3: step = STEP_W'(1);
        default: step = STEP_W'($urandom_range(1, 3600));
      endcase
      case (p % 3)
        0: begin
          beep  = '0;
          count = PHASE_MAX;
        end
        1: begin
          beep  = PHASE_MAX;
          count = '0;
        end
        default: begin
          beep  = PHASE_W'($urandom_range(0, 15));
          count = PHASE_W'($urandom_range(0, 15));
        end
      endcase
      program_timer(step, beep, count, 1'b0);

      // Alternate between idle-heavy phases and stretches with no idling.
      src_burst  = (p % 4 == 1);
      sink_burst = (p % 3 == 0);

      // Fill the block: long receiver hold-off while the sender keeps offering.
      if (p == 3) begin
        hold_req  = 1'b1;
        src_burst = 1'b1;
      end

      // Abort (which leaves set, pause and countdown for idle), then run up set time; the largest step saturates it.
      inc_run = (step == STEP_MAX) ? 18 : $urandom_range(0, 3);
      send_event(make_ev(EV_ABORT, PHASE_W'($urandom_range(0, 15))));
      for (int k = 0; k < inc_run; k++)
        send_event(make_ev(EV_INC, PHASE_W'($urandom_range(0, 15))));

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Pause the sender mid-phase until every result is back.
        if (p == 5 && i == PHASE_ITEMS / 2)
          wait_drained();
        send_event(random_event());
      end
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    src_burst  = 1'b0;
    sink_burst = 1'b1;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
